/* rtl/sbar_pkg.sv */
// ----------------------------------------------------------------------------
// sbar_pkg: shared types, constants and rotation table
// Fixed-point formats, command/status structs between the controller and the
// datapath, and the per-bit rotation table built at elaboration.
// ----------------------------------------------------------------------------
package sbar_pkg;

    // Field widths
    localparam int INT_W      = 33;
    localparam int IN_FRAC_W  = 48;
    localparam int OUT_W      = 32;
    localparam int S_TDATA_W  = ((INT_W + IN_FRAC_W + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W  = 2 * OUT_W;

    // Fraction bits that drive rotations, output fraction bits
    localparam int FRAC_BITS     = 48;
    localparam int OUT_FRAC_BITS = 30;

    // Internal fixed point: signed, Q fraction bits, within +-2^Q
    localparam int Q       = 62;
    localparam int MAG_W   = Q + 1;
    localparam int VAL_W   = Q + 2;
    localparam int SUM_W   = Q + 3;
    localparam int HALF_W  = 32;
    localparam int PROD_W  = 2 * HALF_W;
    localparam int ACC_W   = 2 * PROD_W;

    localparam int TAB_LEN       = 48;
    localparam int IDX_W         = $clog2(TAB_LEN);
    localparam int TAYLOR_TERMS  = 40;

    localparam logic [31:0] MAX_TURNS = 32'hffff_ffff;
    localparam logic [63:0] PI_Q      = 64'hC90F_DAA2_2168_C235;

    typedef logic signed [VAL_W-1:0] val_t;

    localparam val_t ONE_Q = val_t'(64'd1 << Q);

    // Product order within one rotation
    typedef enum logic [1:0] {
        PR_CC = 2'd0,   // cos * table cos
        PR_SS = 2'd1,   // sin * table sin
        PR_CS = 2'd2,   // cos * table sin
        PR_SC = 2'd3    // sin * table cos
    } prod_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_MUL  = 5'b00100,
        S_ROT  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    typedef enum logic [4:0] {
        PH_LATCH = 5'b00001,
        PH_MUL_A = 5'b00010,
        PH_MUL_B = 5'b00100,
        PH_SUM   = 5'b01000,
        PH_ADD   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic             load;
        logic             advance;
        logic             latch;
        logic             mul_a;
        logic             mul_b;
        logic             sum;
        logic             add;
        logic             rot;
        logic             finish;
        prod_t            prod;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic bit_set;
        logic oor;
    } sts_t;

    // Rotation table: [j][0] cos, [j][1] sin of 2*pi*2^-(j+1)
    typedef logic [TAB_LEN-1:0][1:0][VAL_W-1:0] rot_tab_t;

    function automatic logic [63:0] tab_umul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (Q - 1));
        return p[Q+63:Q];
    endfunction

    // Restoring long division, evaluated at elaboration only
    function automatic logic [63:0] tab_udiv(logic [63:0] num, logic [6:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= 65'(den)) begin
                rem    = rem - 65'(den);
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic rot_tab_t build_rot_tab();
        rot_tab_t    tab;
        logic [63:0] one;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] c;
        logic [63:0] s;
        tab = '0;
        one = 64'd1 << Q;
        tab[0][0] = -one;
        tab[1][1] = one;
        for (int j = 2; j < TAB_LEN; j++) begin
            x = (PI_Q >> j) + ((PI_Q >> (j - 1)) & 64'd1);
            t = one;
            c = one;
            s = '0;
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                t = tab_udiv(tab_umul(t, x) + 64'(n >> 1), 7'(n));
                if ((n & 1) != 0) begin
                    if (((n >> 1) & 1) != 0) s = s - t;
                    else                     s = s + t;
                end
                else begin
                    if (((n >> 1) & 1) != 0) c = c - t;
                    else                     c = c + t;
                end
            end
            tab[j][0] = c;
            tab[j][1] = s;
        end
        return tab;
    endfunction

    localparam rot_tab_t ROT_TAB = build_rot_tab();

endpackage

/* rtl/sbar_ctrl.sv */
// ----------------------------------------------------------------------------
// sbar_ctrl: sequencing controller
// Walks the fraction bits MSB first, runs four products per set bit through
// the shared multiplier pair, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module sbar_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  sbar_pkg::sts_t  sts,
    output sbar_pkg::cmd_t  cmd
);
    import sbar_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAC_BITS - 1);

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    prod_t            prod_reg, prod_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        prod_next  = prod_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.prod   = prod_reg;
        cmd.idx    = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (sts.oor)
                begin
                    state_next = S_DONE;
                end
                else if (sts.bit_set)
                begin
                    phase_next = PH_LATCH;
                    prod_next  = PR_CC;
                    state_next = S_MUL;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // skip a clear bit
                    cmd.advance = 1'b1;
                    idx_next    = idx_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                unique case (phase_reg)
                    PH_LATCH:
                    begin
                        cmd.latch  = 1'b1;
                        phase_next = PH_MUL_A;
                    end
                    PH_MUL_A:
                    begin
                        cmd.mul_a  = 1'b1;
                        phase_next = PH_MUL_B;
                    end
                    PH_MUL_B:
                    begin
                        cmd.mul_b  = 1'b1;
                        phase_next = PH_SUM;
                    end
                    PH_SUM:
                    begin
                        cmd.sum    = 1'b1;
                        phase_next = PH_ADD;
                    end
                    PH_ADD:
                    begin
                        cmd.add    = 1'b1;
                        phase_next = PH_LATCH;
                        unique case (prod_reg)
                            PR_CC: prod_next = PR_SS;
                            PR_SS: prod_next = PR_CS;
                            PR_CS: prod_next = PR_SC;
                            PR_SC: state_next = S_ROT;
                            default: prod_next = PR_CC;
                        endcase
                    end
                    default: phase_next = PH_LATCH;
                endcase
            end
            S_ROT:
            begin
                cmd.rot = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;
        if (cmd.finish)
            m_tvalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_LATCH;
            prod_reg     <= PR_CC;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            prod_reg     <= prod_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

/* rtl/sbar_dpath.sv */
// ----------------------------------------------------------------------------
// sbar_dpath: rotation datapath
// Holds the angle, the running cos/sin pair, a shared pair of 32x32
// multipliers with a partial product accumulator, and the output register.
// ----------------------------------------------------------------------------
module sbar_dpath (
    input  logic                             clk,
    input  logic [sbar_pkg::S_TDATA_W-1:0]   s_tdata,
    input  sbar_pkg::cmd_t                   cmd,
    output sbar_pkg::sts_t                   sts,
    output logic [sbar_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser
);
    import sbar_pkg::*;

    localparam int OUT_SH    = Q - OUT_FRAC_BITS;
    localparam int OUT_SH_M1 = (OUT_SH > 0) ? OUT_SH - 1 : 0;
    localparam logic [VAL_W-1:0] OUT_RND = (OUT_SH > 0) ? (64'd1 << OUT_SH_M1) : 64'd0;
    localparam logic [ACC_W-1:0] ACC_RND = ACC_W'(1) << (Q - 1);
    localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(ONE_Q);

    // Saturate to +-2^Q
    function automatic val_t sat_q(logic signed [SUM_W-1:0] v);
        if (v > ONE_SUM)
            return ONE_Q;
        else if (v < -ONE_SUM)
            return -ONE_Q;
        else
            return v[VAL_W-1:0];
    endfunction

    // Round Q to OUT_FRAC_BITS fraction bits, half away from zero, keep low bits
    function automatic logic [OUT_W-1:0] to_out(val_t v);
        val_t             nv;
        logic [MAG_W-1:0] mag;
        logic [VAL_W-1:0] r;
        nv  = -v;
        mag = v[VAL_W-1] ? nv[MAG_W-1:0] : v[MAG_W-1:0];
        r   = ({1'b0, mag} + OUT_RND) >> OUT_SH;
        return v[VAL_W-1] ? -r[OUT_W-1:0] : r[OUT_W-1:0];
    endfunction

    // Input unpacking
    logic [INT_W-1:0]     in_int;
    logic [IN_FRAC_W-1:0] in_frac;
    logic                 in_neg;
    logic                 in_oor;

    assign in_int  = s_tdata[INT_W-1:0];
    assign in_frac = s_tdata[INT_W +: IN_FRAC_W];
    assign in_neg  = s_tdata[INT_W + IN_FRAC_W];
    assign in_oor  = in_int[INT_W-1] ||
                     ((in_int[31:0] == MAX_TURNS) && (in_frac != '0));

    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic                 oor_reg, oor_next;
    logic                 neg_reg, neg_next;
    val_t                 co_reg, co_next;
    val_t                 si_reg, si_next;
    logic [MAG_W-1:0]     a_mag_reg, a_mag_next;
    logic [MAG_W-1:0]     b_mag_reg, b_mag_next;
    logic                 pneg_reg, pneg_next;
    logic [PROD_W-1:0]    mul_x_reg, mul_x_next;
    logic [PROD_W-1:0]    mul_y_reg, mul_y_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [SUM_W-1:0] nc_reg, nc_next;
    logic signed [SUM_W-1:0] ns_reg, ns_next;
    logic [OUT_W-1:0]     cos_out_reg, cos_out_next;
    logic [OUT_W-1:0]     sin_out_reg, sin_out_next;
    logic                 status_reg, status_next;

    assign sts.bit_set = frac_reg[FRAC_BITS-1];
    assign sts.oor     = oor_reg;

    // Table and operand selection
    val_t tab_c, tab_s, op_a, op_b, op_a_neg, op_b_neg, si_fin;
    assign tab_c    = ROT_TAB[cmd.idx][0];
    assign tab_s    = ROT_TAB[cmd.idx][1];
    assign op_a     = (cmd.prod == PR_CC || cmd.prod == PR_CS) ? co_reg : si_reg;
    assign op_b     = (cmd.prod == PR_CC || cmd.prod == PR_SC) ? tab_c : tab_s;
    assign op_a_neg = -op_a;
    assign op_b_neg = -op_b;
    assign si_fin   = neg_reg ? -si_reg : si_reg;

    // Shared multiplier pair: low/high halves, crossed on the second pass
    logic [HALF_W-1:0] a_lo, a_hi, b_lo, b_hi;
    logic [HALF_W-1:0] m0a, m0b, m1a, m1b;
    logic [PROD_W-1:0] prod0, prod1;
    logic [PROD_W:0]   cross_sum;
    logic [MAG_W-1:0]  prod_mag;
    logic signed [SUM_W-1:0] prod_ext, prod_val;

    assign a_lo  = a_mag_reg[HALF_W-1:0];
    assign a_hi  = {{(2*HALF_W-MAG_W){1'b0}}, a_mag_reg[MAG_W-1:HALF_W]};
    assign b_lo  = b_mag_reg[HALF_W-1:0];
    assign b_hi  = {{(2*HALF_W-MAG_W){1'b0}}, b_mag_reg[MAG_W-1:HALF_W]};
    assign m0a   = a_lo;
    assign m0b   = cmd.mul_b ? b_hi : b_lo;
    assign m1a   = a_hi;
    assign m1b   = cmd.mul_b ? b_lo : b_hi;
    assign prod0 = m0a * m0b;
    assign prod1 = m1a * m1b;
    assign cross_sum = {1'b0, mul_x_reg} + {1'b0, mul_y_reg};

    assign prod_mag = acc_reg[Q +: MAG_W];
    assign prod_ext = {{(SUM_W-MAG_W){1'b0}}, prod_mag};
    assign prod_val = pneg_reg ? -prod_ext : prod_ext;

    always_comb
    begin
        frac_next    = frac_reg;
        oor_next     = oor_reg;
        neg_next     = neg_reg;
        co_next      = co_reg;
        si_next      = si_reg;
        a_mag_next   = a_mag_reg;
        b_mag_next   = b_mag_reg;
        pneg_next    = pneg_reg;
        mul_x_next   = mul_x_reg;
        mul_y_next   = mul_y_reg;
        acc_next     = acc_reg;
        nc_next      = nc_reg;
        ns_next      = ns_reg;
        cos_out_next = cos_out_reg;
        sin_out_next = sin_out_reg;
        status_next  = status_reg;

        if (cmd.load)
        begin
            frac_next = in_frac[IN_FRAC_W-1 -: FRAC_BITS];
            oor_next  = in_oor;
            neg_next  = in_neg;
            co_next   = ONE_Q;
            si_next   = '0;
        end

        if (cmd.advance)
            frac_next = frac_reg << 1;

        if (cmd.latch)
        begin
            a_mag_next = op_a[VAL_W-1] ? op_a_neg[MAG_W-1:0] : op_a[MAG_W-1:0];
            b_mag_next = op_b[VAL_W-1] ? op_b_neg[MAG_W-1:0] : op_b[MAG_W-1:0];
            // the sin*sin term enters the new cosine with a minus sign
            pneg_next  = op_a[VAL_W-1] ^ op_b[VAL_W-1] ^ (cmd.prod == PR_SS);
        end

        if (cmd.mul_a || cmd.mul_b)
        begin
            mul_x_next = prod0;
            mul_y_next = prod1;
        end

        if (cmd.mul_b)
            acc_next = {mul_y_reg, mul_x_reg} + ACC_RND;

        if (cmd.sum)
            acc_next = acc_reg + (ACC_W'(cross_sum) << HALF_W);

        if (cmd.add)
        begin
            unique case (cmd.prod)
                PR_CC: nc_next = prod_val;
                PR_SS: nc_next = nc_reg + prod_val;
                PR_CS: ns_next = prod_val;
                PR_SC: ns_next = ns_reg + prod_val;
                default: nc_next = nc_reg;
            endcase
        end

        if (cmd.rot)
        begin
            co_next = sat_q(nc_reg);
            si_next = sat_q(ns_reg);
        end

        if (cmd.finish)
        begin
            cos_out_next = to_out(oor_reg ? ONE_Q : co_reg);
            sin_out_next = oor_reg ? '0 : to_out(si_fin);
            status_next  = oor_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg    <= frac_next;
        oor_reg     <= oor_next;
        neg_reg     <= neg_next;
        co_reg      <= co_next;
        si_reg      <= si_next;
        a_mag_reg   <= a_mag_next;
        b_mag_reg   <= b_mag_next;
        pneg_reg    <= pneg_next;
        mul_x_reg   <= mul_x_next;
        mul_y_reg   <= mul_y_next;
        acc_reg     <= acc_next;
        nc_reg      <= nc_next;
        ns_reg      <= ns_next;
        cos_out_reg <= cos_out_next;
        sin_out_reg <= sin_out_next;
        status_reg  <= status_next;
    end

    assign m_tdata = {sin_out_reg, cos_out_reg};
    assign m_tuser = status_reg;

endmodule

/* rtl/sincos_binary_angle_rotation_core.sv */
// ----------------------------------------------------------------------------
// sincos_binary_angle_rotation_core: sine and cosine of an angle in turns
// Rotates (1, 0) by a tabled angle for each set fraction bit, MSB first.
//
//   Channel | Direction | Handshake          | Payload
//   s_*     | in        | s_tvalid/s_tready  | turns_integer, turns_fraction,
//           |           |                    | angle_negative
//   m_*     | out       | m_tvalid/m_tready  | cos_value, sin_value; status
//
// One angle at a time: the controller scans each clear fraction bit and runs
// a rotation for each set bit; an out-of-range angle goes from the scan straight
// to the final step. A rotation is four products, each taking five steps through the
// single pair of 32x32 multipliers. A new angle is taken while a result still
// waits in the output register; the final step holds until it is free.
// Reset clears the controller; the datapath registers carry no reset.
// ----------------------------------------------------------------------------
module sincos_binary_angle_rotation_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [32:0] turns_integer, [80:33] turns_fraction, [81] angle_negative
    input  logic [sbar_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] cos_value, [63:32] sin_value
    output logic [sbar_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] status
    output logic                             m_tuser
);
    import sbar_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sbar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sbar_dpath u_dpath (
        .clk     (clk),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sincos_binary_angle_rotation_core
// Feeds angles in turns through the input stream and checks every cosine,
// sine and status against a bit-exact predictor of the table-driven
// rotation. A directed burst comes first, then random angles in phases with
// neither, sender idling, receiver stalling, and both.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sbar_pkg::*;

    localparam int          ROT_Q       = 62;
    localparam int          ROT_STEPS   = 48;
    localparam int          TERMS       = 40;
    localparam logic [63:0] PI_Q62      = 64'hC90F_DAA2_2168_C235;
    localparam logic signed [63:0] UNITY = 64'sh4000_0000_0000_0000;
    localparam logic signed [65:0] UNITY_W = 66'sh4000_0000_0000_0000;
    localparam int          CYCLE_LIMIT = 4_000_000;
    localparam int          SETTLE      = 1100;
    localparam int          PHASE_ITEMS = 284;

    typedef struct packed {
        logic [31:0] cos_value;
        logic [31:0] sin_value;
        logic        status;
    } trig_t;

    typedef struct {
        logic [INT_W-1:0]     turns;
        logic [IN_FRAC_W-1:0] frac;
        logic                 negative;
        int                   gap_pct;
        int                   stall_pct;
        bit                   drain;
    } angle_item_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    logic signed [63:0] rot_cos [ROT_STEPS];
    logic signed [63:0] rot_sin [ROT_STEPS];

    angle_item_t angle_backlog [$];
    trig_t       awaited_sincos [$];
    int          n_sent = 0;
    int          n_got = 0;
    int          n_err = 0;
    int          rx_stall_pct = 0;
    int          cycles = 0;

    sincos_binary_angle_rotation_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Unsigned product rounded half up to 62 fraction bits
    function automatic logic [63:0] mul_round_q(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (ROT_Q - 1));
        return p[ROT_Q+63:ROT_Q];
    endfunction

    // Signed product, magnitude rounded so that halves go away from zero
    function automatic logic signed [63:0] mul_signed_q(logic signed [63:0] a,
                                                       logic signed [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] m;
        ma = a[63] ? 64'(-a) : 64'(a);
        mb = b[63] ? 64'(-b) : 64'(b);
        m  = mul_round_q(ma, mb);
        return (a[63] != b[63]) ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] clamp_unity(logic signed [65:0] v);
        if (v > UNITY_W)
            return UNITY;
        if (v < -UNITY_W)
            return -UNITY;
        return v[63:0];
    endfunction

    function automatic logic [31:0] to_fixed_out(logic signed [63:0] v);
        int                 sh;
        logic [63:0]        m;
        logic signed [63:0] r;
        sh = ROT_Q - OUT_FRAC_BITS;
        m  = v[63] ? 64'(-v) : 64'(v);
        if (sh > 0)
            m = (m + (64'd1 << (sh - 1))) >> sh;
        r = v[63] ? -$signed(m) : $signed(m);
        return r[31:0];
    endfunction

    // cos/sin of 2*pi*2^-(j+1) from alternating Taylor sums in 64-bit unsigned
    function automatic void build_rotations();
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] c;
        logic [63:0] s;
        rot_cos[0] = -UNITY;
        rot_sin[0] = '0;
        rot_cos[1] = '0;
        rot_sin[1] = UNITY;
        for (int j = 2; j < ROT_STEPS; j++)
        begin
            x = (PI_Q62 >> j) + ((PI_Q62 >> (j - 1)) & 64'd1);
            t = UNITY;
            c = UNITY;
            s = '0;
            for (int n = 1; n <= TERMS; n++)
            begin
                t = (mul_round_q(t, x) + 64'(n / 2)) / 64'(n);
                if (n % 2 == 1)
                begin
                    if ((n / 2) % 2 == 1) s = s - t;
                    else                  s = s + t;
                end
                else
                begin
                    if ((n / 2) % 2 == 1) c = c - t;
                    else                  c = c + t;
                end
            end
            rot_cos[j] = c;
            rot_sin[j] = s;
        end
    endfunction

    function automatic trig_t predict_sincos(logic [INT_W-1:0] turns,
                                             logic [IN_FRAC_W-1:0] frac,
                                             logic negative);
        trig_t              r;
        logic signed [63:0] co;
        logic signed [63:0] si;
        logic signed [63:0] p_cc;
        logic signed [63:0] p_ss;
        logic signed [63:0] p_cs;
        logic signed [63:0] p_sc;
        logic signed [65:0] wa;
        logic signed [65:0] wb;
        r.status = 1'b0;
        co = UNITY;
        si = '0;
        if (turns[32] || (turns[31:0] == 32'hffff_ffff && frac != '0))
        begin
            r.cos_value = to_fixed_out(UNITY);
            r.sin_value = '0;
            r.status    = 1'b1;
            return r;
        end
        // Only the top FRAC_BITS fraction bits rotate; MSB first
        for (int j = 0; j < FRAC_BITS && j < ROT_STEPS; j++)
        begin
            if (frac[IN_FRAC_W-1-j])
            begin
                p_cc = mul_signed_q(co, rot_cos[j]);
                p_ss = mul_signed_q(si, rot_sin[j]);
                p_cs = mul_signed_q(co, rot_sin[j]);
                p_sc = mul_signed_q(si, rot_cos[j]);
                wa = p_cc;
                wb = p_ss;
                co = clamp_unity(wa - wb);
                wa = p_cs;
                wb = p_sc;
                si = clamp_unity(wa + wb);
            end
        end
        if (negative)
            si = -si;
        r.cos_value = to_fixed_out(co);
        r.sin_value = to_fixed_out(si);
        return r;
    endfunction

    task automatic queue_angle(logic [INT_W-1:0] turns, logic [IN_FRAC_W-1:0] frac,
                               logic negative, int gap_pct, int stall_pct, bit drain);
        angle_item_t a;
        a.turns     = turns;
        a.frac      = frac;
        a.negative  = negative;
        a.gap_pct   = gap_pct;
        a.stall_pct = stall_pct;
        a.drain     = drain;
        angle_backlog.push_back(a);
    endtask

    task automatic queue_random_angles(int count, int gap_pct, int stall_pct);
        logic [INT_W-1:0]     ti;
        logic [IN_FRAC_W-1:0] tf;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 19))
                0:       ti = {1'b1, 32'($urandom())};
                1:       ti = {1'b0, 32'hffff_ffff};
                2, 3:    ti = 33'($urandom_range(0, 3));
                default: ti = {1'b0, 32'($urandom())};
            endcase
            case ($urandom_range(0, 9))
                0:          tf = '0;
                1:          tf = '1;
                2, 3, 4, 5: tf = {16'($urandom()), 32'($urandom())};
                default:
                begin
                    // few set bits keep the rotation count, and the run, short
                    tf = '0;
                    repeat ($urandom_range(1, 4))
                        tf[$urandom_range(0, IN_FRAC_W - 1)] = 1'b1;
                end
            endcase
            queue_angle(ti, tf, 1'($urandom()), gap_pct, stall_pct,
                        k == 0 || $urandom_range(0, 63) == 0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Driver: present the next angle once the current transaction is done
    always @(posedge clk or negedge rst_n)
    begin
        angle_item_t          head;
        logic                 nxt_valid;
        logic [S_TDATA_W-1:0] nxt_data;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                awaited_sincos.push_back(predict_sincos(s_tdata[INT_W-1:0],
                    s_tdata[INT_W+IN_FRAC_W-1:INT_W], s_tdata[INT_W+IN_FRAC_W]));
                n_sent <= n_sent + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                nxt_valid = 1'b0;
                nxt_data  = '0;
                if (angle_backlog.size() != 0)
                begin
                    head = angle_backlog[0];
                    // hold a draining item until every result is back
                    if (!(head.drain && (n_sent != n_got || s_tvalid))
                        && $urandom_range(0, 99) >= head.gap_pct)
                    begin
                        void'(angle_backlog.pop_front());
                        nxt_valid = 1'b1;
                        nxt_data[INT_W-1:0] = head.turns;
                        nxt_data[INT_W+IN_FRAC_W-1:INT_W] = head.frac;
                        nxt_data[INT_W+IN_FRAC_W] = head.negative;
                        rx_stall_pct <= head.stall_pct;
                    end
                end
                s_tvalid <= nxt_valid;
                s_tdata  <= nxt_data;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        trig_t want;
        int    bad;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                bad = 0;
                n_got <= n_got + 1;
                if (awaited_sincos.size() == 0)
                begin
                    $error("unexpected result: cos %h sin %h status %b",
                           m_tdata[31:0], m_tdata[63:32], m_tuser);
                    bad = bad + 1;
                end
                else
                begin
                    want = awaited_sincos.pop_front();
                    if (m_tdata[31:0] !== want.cos_value)
                    begin
                        $error("cos_value: expected %h, got %h", want.cos_value,
                               m_tdata[31:0]);
                        bad = bad + 1;
                    end
                    if (m_tdata[63:32] !== want.sin_value)
                    begin
                        $error("sin_value: expected %h, got %h", want.sin_value,
                               m_tdata[63:32]);
                        bad = bad + 1;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %b, got %b", want.status, m_tuser);
                        bad = bad + 1;
                    end
                end
                if (bad != 0)
                    n_err <= n_err + bad;
            end
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial
    begin
        build_rotations();

        // Directed: zero, quarter steps, extremes of every field, range edges
        queue_angle('0, '0, 1'b0, 0, 0, 1'b0);
        queue_angle('0, 48'h8000_0000_0000, 1'b0, 0, 0, 1'b0);
        queue_angle('0, 48'h8000_0000_0000, 1'b1, 0, 0, 1'b0);
        queue_angle('0, 48'h4000_0000_0000, 1'b0, 0, 0, 1'b0);
        queue_angle('0, 48'h4000_0000_0000, 1'b1, 0, 0, 1'b0);
        queue_angle('0, 48'hC000_0000_0000, 1'b0, 0, 0, 1'b0);
        queue_angle('0, 48'h2000_0000_0000, 1'b1, 0, 0, 1'b0);
        queue_angle('0, 48'h0000_0000_0001, 1'b0, 0, 0, 1'b0);
        queue_angle('0, 48'h0000_0000_0001, 1'b1, 0, 0, 1'b0);
        queue_angle('0, '1, 1'b0, 0, 0, 1'b0);
        queue_angle('0, '1, 1'b1, 0, 0, 1'b0);
        queue_angle(33'd12345, 48'h5555_5555_5555, 1'b0, 0, 0, 1'b0);
        queue_angle(33'd7, 48'hAAAA_AAAA_AAAA, 1'b1, 0, 0, 1'b0);
        queue_angle({1'b0, 32'hffff_ffff}, '0, 1'b1, 0, 0, 1'b0);
        queue_angle({1'b0, 32'hffff_ffff}, 48'h0000_0000_0001, 1'b0, 0, 0, 1'b0);
        queue_angle({1'b0, 32'hffff_ffff}, '1, 1'b1, 0, 0, 1'b0);
        queue_angle({1'b1, 32'h0}, '0, 1'b0, 0, 0, 1'b0);
        queue_angle('1, '1, 1'b1, 0, 0, 1'b0);
        queue_angle({1'b1, 32'h0}, 48'h8000_0000_0000, 1'b1, 0, 0, 1'b0);
        queue_angle({1'b0, 32'hffff_fffe}, 48'h1234_5678_9ABC, 1'b0, 0, 0, 1'b0);

        queue_random_angles(PHASE_ITEMS, 0, 0);
        queue_random_angles(PHASE_ITEMS, 82, 0);
        queue_random_angles(PHASE_ITEMS, 0, 82);
        queue_random_angles(PHASE_ITEMS, 27, 27);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (angle_backlog.size() != 0 || s_tvalid || n_sent != n_got)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (awaited_sincos.size() != 0)
            $error("%0d results never arrived", awaited_sincos.size());
        if (n_err == 0 && awaited_sincos.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
rtl/sbar_pkg.sv
rtl/sbar_ctrl.sv
rtl/sbar_dpath.sv
rtl/sincos_binary_angle_rotation_core.sv
tb/testbench.sv
